[hdl/rcpdm_pkg.sv]
// ----------------------------------------------------------------------------
// rcpdm_pkg: shared types and constants for the RC-feedback PDM modulator
// Field widths, fixed-point formats, register indexes and the dither
// generator step.
// ----------------------------------------------------------------------------
package rcpdm_pkg;

    // Framing: pulse-density bits per PCM sample, packed into 32-bit words
    localparam int PDM_BITS        = 128;
    localparam int BIT_CNT_W       = $clog2(PDM_BITS);
    localparam int WORD_W          = 32;
    localparam int WPOS_W          = $clog2(WORD_W);
    localparam int WORDS           = PDM_BITS / WORD_W;
    localparam int WIDX_W          = 2;

    // Sample and level formats
    localparam int SAMPLE_W     = 16;
    localparam int TARGET_SHIFT = 13;
    localparam int TARGET_W     = SAMPLE_W + TARGET_SHIFT;
    localparam int DIFF_W       = TARGET_W + 1;
    localparam int ACC_W        = DIFF_W + BIT_CNT_W + 1;
    localparam int DES_W        = TARGET_W + 1;

    // RC filter model
    localparam int FULL_SCALE_LOG2 = 29;
    localparam int DECAY_SHIFT     = 6;
    localparam int V_W             = FULL_SCALE_LOG2 + 1;
    localparam logic [V_W-1:0] RC_STEP      = V_W'(1) << (FULL_SCALE_LOG2 - DECAY_SHIFT);
    localparam logic [V_W-1:0] RC_HALF_STEP = RC_STEP >> 1;
    localparam logic [V_W-1:0] V_MAX        = V_W'(1) << FULL_SCALE_LOG2;

    // Feedback error, saturated to +-2^30
    localparam int ERR_W    = 32;
    localparam int SUM_W    = ERR_W + 2;
    localparam int ERR_BOUND_LOG2 = 30;
    localparam logic signed [SUM_W-1:0] ERR_MAX = SUM_W'(1) <<< ERR_BOUND_LOG2;
    localparam logic signed [SUM_W-1:0] ERR_MIN = -ERR_MAX;

    // Dither
    localparam int SEED_W  = 32;
    localparam int GAIN_W  = 7;
    localparam int DITH_W  = 18;
    localparam int NOISE_W = 25;
    localparam logic [DITH_W-1:0] DITH_OFFSET = DITH_W'(65535);
    localparam logic [SEED_W-1:0] SEED_RESET  = SEED_W'(8266);
    localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(32);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PRNG_SEED   = CFG_IDX_W'(2);

    typedef struct packed {
        logic load;
        logic advance;
    } dith_ctrl_t;

    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] r;
        r = s;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        return r;
    endfunction

endpackage

[hdl/rcpdm_in_if.sv]
// ----------------------------------------------------------------------------
// rcpdm_in_if: PCM sample channel
// Valid/ready channel carrying one signed 16-bit sample per word.
// ----------------------------------------------------------------------------
interface rcpdm_in_if import rcpdm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[hdl/rcpdm_out_if.sv]
// ----------------------------------------------------------------------------
// rcpdm_out_if: PDM word channel
// Valid/ready channel carrying 32 PDM bits with their position in the sample.
// ----------------------------------------------------------------------------
interface rcpdm_out_if import rcpdm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pdm_word;
    logic [WIDX_W-1:0] word_index;
    logic              last_word;

    modport source (output valid, output pdm_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input pdm_word, input word_index, input last_word,
                    output ready);
endinterface

[hdl/rcpdm_dither.sv]
// ----------------------------------------------------------------------------
// rcpdm_dither: triangular dither source
// xorshift32 generator; each step registers the sum of its two halves,
// re-centred and scaled by the dither gain.
// ----------------------------------------------------------------------------
module rcpdm_dither import rcpdm_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dith_ctrl_t                ctrl,
    input  logic [SEED_W-1:0]         seed,
    input  logic [GAIN_W-1:0]         gain,
    output logic signed [NOISE_W-1:0] noise
);

    logic [SEED_W-1:0]                state_reg;
    logic [SEED_W-1:0]                state_next;
    logic signed [NOISE_W-1:0]        noise_reg;
    logic signed [DITH_W-1:0]         tri_val;
    logic signed [DITH_W+GAIN_W:0]    product;

    always_comb
    begin
        state_next = xorshift32(state_reg);
        tri_val    = $signed(DITH_W'(state_next[15:0]) + DITH_W'(state_next[31:16])
                             - DITH_OFFSET);
        product    = tri_val * $signed({1'b0, gain});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEED_RESET;
        end
        else
        begin
            if (ctrl.load)
            begin
                state_reg <= seed;
            end
            else if (ctrl.advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // noise value is payload: no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            noise_reg <= product[NOISE_W-1:0];
        end
    end

    assign noise = noise_reg;

endmodule

[hdl/rc_feedback_pdm_modulator.sv]
// ----------------------------------------------------------------------------
// rc_feedback_pdm_modulator: error-feedback PDM modulator with TPDF dither
// Turns each PCM sample into 128 pulse-density bits against a model of an RC
// output filter, delivered as four 32-bit words, earliest bit in the MSB.
// ----------------------------------------------------------------------------
//
//  channel  | dir | words per sample | payload
//  ---------+-----+------------------+-------------------------------------
//  pcm      | in  | 1                | sample (s16)
//  pdm      | out | 4                | pdm_word (32), word_index (2), last_word
//  cfg_*    | in  | any, while idle  | cfg_index (2), cfg_wdata (32)
//
// Each sample passes through the accept cycle, a priming cycle for the dither
// and interpolation registers, then the bit loop at one bit per cycle while
// no stall holds it. The rate is set by the loop: each bit needs the RC voltage
// and error left by the one before it, and one shared bit unit evaluates them.
// pcm.ready is high only while the sequencer is idle.
// A full output register holds the bit loop at the last bit of a word until
// the word is taken; no other stall exists.
// Reset clears the RC voltage, error and previous target, loads the seed
// 8266 into the generator and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module rc_feedback_pdm_modulator import rcpdm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    rcpdm_in_if.sink              pcm,
    rcpdm_out_if.source           pdm
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    // sequencer and state
    logic [1:0]                state_reg, state_next;
    logic [BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [V_W-1:0]            v_reg, v_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [TARGET_W-1:0]       last_target_reg, last_target_next;

    // configuration
    logic                      simple_thr_reg;
    logic [GAIN_W-1:0]         gain_reg;

    // per-sample payload
    logic [TARGET_W-1:0]       target_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [DES_W-1:0]          desired_reg;
    logic [WORD_W-1:0]         pack_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]         out_word_reg;
    logic [WIDX_W-1:0]         out_index_reg;
    logic                      out_last_reg;

    // control
    logic                      in_fire;
    logic                      word_end;
    logic                      last_bit;
    logic                      stall;
    logic                      run_adv;
    logic                      prep_go;
    logic                      emit;
    dith_ctrl_t                dith_ctrl;
    logic signed [NOISE_W-1:0] noise;

    // interpolation datapath
    logic [TARGET_W-1:0]       target_in;
    logic signed [DIFF_W-1:0]  diff_in;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_bias;
    logic signed [ACC_W-1:0]   quot;
    logic [DES_W-1:0]          desired_next;

    // bit unit datapath
    logic [V_W-1:0]            v_down;
    logic [V_W-1:0]            v_up;
    logic [V_W-1:0]            thr;
    logic signed [SUM_W-1:0]   lhs;
    logic                      high;
    logic signed [SUM_W-1:0]   err_raw;
    logic signed [SUM_W-1:0]   err_sat;

    assign pcm.ready = (state_reg == ST_IDLE);
    assign in_fire   = pcm.valid && pcm.ready;
    assign word_end  = &bit_cnt_reg[WPOS_W-1:0];
    assign last_bit  = (bit_cnt_reg == BIT_CNT_W'(PDM_BITS - 1));
    // hold the loop at a word boundary while the previous word waits
    assign stall     = word_end && out_valid_reg && !pdm.ready;
    assign run_adv   = (state_reg == ST_RUN) && !stall;
    assign prep_go   = (state_reg == ST_PREP) || (run_adv && !last_bit);
    assign emit      = run_adv && word_end;

    // Target level: (sample + 32768) * 8192, i.e. flip the sign bit and shift
    always_comb
    begin
        target_in = {~pcm.sample[SAMPLE_W-1], pcm.sample[SAMPLE_W-2:0],
                     {TARGET_SHIFT{1'b0}}};
        diff_in   = $signed({1'b0, target_in}) - $signed({1'b0, last_target_reg});
    end

    // Interpolation: acc holds diff * (bit + 1); divide by the bit count with
    // truncation toward zero by biasing negative values before the shift.
    always_comb
    begin
        acc_sum      = acc_reg + {{(ACC_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
        acc_bias     = acc_sum + (acc_sum[ACC_W-1] ? ACC_W'(PDM_BITS - 1)
                                                   : ACC_W'(0));
        quot         = acc_bias >>> BIT_CNT_W;
        desired_next = {1'b0, last_target_reg} + quot[DES_W-1:0];
    end

    // Shared bit unit: RC decay, threshold, decision, error update
    always_comb
    begin
        v_down = v_reg - (v_reg >> DECAY_SHIFT);
        v_up   = v_down + RC_STEP;
        // midpoint of up and down is exactly down + half a step
        thr    = simple_thr_reg ? v_reg : (v_down + RC_HALF_STEP);
        lhs    = $signed({{(SUM_W-DES_W){desired_reg[DES_W-1]}}, desired_reg})
               + $signed({{(SUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg})
               + $signed({{(SUM_W-NOISE_W){noise[NOISE_W-1]}}, noise});
        high   = lhs > $signed({{(SUM_W-V_W){1'b0}}, thr});
        v_next = high ? v_up : v_down;
        err_raw = $signed({{(SUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg})
                + $signed({{(SUM_W-DES_W){desired_reg[DES_W-1]}}, desired_reg})
                - $signed({{(SUM_W-V_W){1'b0}}, v_next});
        priority if (err_raw > ERR_MAX)
        begin
            err_sat = ERR_MAX;
        end
        else if (err_raw < ERR_MIN)
        begin
            err_sat = ERR_MIN;
        end
        else
        begin
            err_sat = err_raw;
        end
        err_next = err_sat[ERR_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        bit_cnt_next     = bit_cnt_reg;
        last_target_next = last_target_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next   = ST_RUN;
                bit_cnt_next = '0;
            end
            ST_RUN:
            begin
                if (run_adv)
                begin
                    bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                    if (last_bit)
                    begin
                        state_next       = ST_IDLE;
                        last_target_next = target_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (pdm.ready ? 1'b0 : out_valid_reg);

    assign dith_ctrl.load    = cfg_wen && (cfg_index == REG_PRNG_SEED);
    assign dith_ctrl.advance = prep_go;

    rcpdm_dither u_dither (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dith_ctrl),
        .seed  (cfg_wdata[SEED_W-1:0]),
        .gain  (gain_reg),
        .noise (noise)
    );

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bit_cnt_reg     <= '0;
            v_reg           <= '0;
            err_reg         <= '0;
            last_target_reg <= '0;
            out_valid_reg   <= 1'b0;
            simple_thr_reg  <= 1'b0;
            gain_reg        <= GAIN_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            bit_cnt_reg     <= bit_cnt_next;
            last_target_reg <= last_target_next;
            out_valid_reg   <= out_valid_next;
            if (run_adv)
            begin
                v_reg   <= v_next;
                err_reg <= err_next;
            end
            if (cfg_wen && (cfg_index == REG_SIMPLE_THR))
            begin
                simple_thr_reg <= cfg_wdata[0];
            end
            if (cfg_wen && (cfg_index == REG_DITHER_GAIN))
            begin
                gain_reg <= cfg_wdata[GAIN_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            target_reg <= target_in;
            diff_reg   <= diff_in;
            acc_reg    <= '0;
        end
        else if (prep_go)
        begin
            acc_reg     <= acc_sum;
            desired_reg <= desired_next;
        end
        if (run_adv)
        begin
            pack_reg <= {pack_reg[WORD_W-2:0], high};
        end
        if (emit)
        begin
            out_word_reg  <= {pack_reg[WORD_W-2:0], high};
            out_index_reg <= bit_cnt_reg[WPOS_W +: WIDX_W];
            out_last_reg  <= last_bit;
        end
    end

    assign pdm.valid      = out_valid_reg;
    assign pdm.pdm_word   = out_word_reg;
    assign pdm.word_index = out_index_reg;
    assign pdm.last_word  = out_last_reg;

    // A new word never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && !pdm.ready))
        else $error("word emitted over an untaken word");

    // The final word of a sample carries the last index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (pdm.valid && pdm.last_word) |-> (pdm.word_index == WIDX_W'(WORDS - 1)))
        else $error("last_word on wrong word_index");

    // An accepted sample primes the dither before its first bit
    a_prep_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_PREP))
        else $error("accepted sample not followed by priming cycle");

    // Error stays within its saturation bounds
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ($signed({{(SUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg}) <= ERR_MAX) &&
        ($signed({{(SUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg}) >= ERR_MIN))
        else $error("feedback error out of bounds");

    // RC voltage never passes full scale
    a_v_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg <= V_MAX)
        else $error("RC voltage above full scale");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for rc_feedback_pdm_modulator
// Streams PCM samples in and checks every 32-bit PDM word that comes out
// against a bit-exact predictor of the dithered RC-feedback loop. It covers
// directed extremes first, then random phases with changing registers and
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import rcpdm_pkg::*;

    // Run-control figures
    localparam int RANDOM_ITEMS     = 138;
    localparam int SETTLE_CYCLES    = 140;     // one full sample plus margin
    localparam int SINK_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT      = 1000000;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    // Sample sequence shapes for the random part
    typedef enum int {SEQ_NOISE, SEQ_WALK, SEQ_HOLD, SEQ_SWING} seq_kind_e;

    // One expected PDM word
    typedef struct {
        logic [WORD_W-1:0] pattern;
        logic [WIDX_W-1:0] word_index;
        logic              last_word;
    } pdm_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: runs the modulator loop bit by bit on each accepted sample
    // and keeps the words it should produce, oldest first.
    // ------------------------------------------------------------------------
    class pdm_bit_predictor;
        bit                thr_simple;
        bit [GAIN_W-1:0]   dither_mult;
        bit [SEED_W-1:0]   lfsr;
        longint            v_rc;
        longint            err_fb;
        longint            prev_level;
        pdm_word_t         words_due[$];
        int                errors;

        function new();
            thr_simple  = 1'b0;
            dither_mult = GAIN_RESET;
            lfsr        = SEED_RESET;
            v_rc        = 0;
            err_fb      = 0;
            prev_level  = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SIMPLE_THR:  thr_simple  = data[0];
                REG_DITHER_GAIN: dither_mult = data[GAIN_W-1:0];
                REG_PRNG_SEED:   lfsr        = data[SEED_W-1:0];
                default:         ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] pcm);
            longint          level;
            longint          span;
            longint          desired;
            longint          noise;
            longint          down;
            longint          up;
            longint          thr;
            longint          bound;
            bit [SEED_W-1:0] r;
            bit [WORD_W-1:0] shreg;
            bit              pulse;
            pdm_word_t       w;
            level = (longint'(pcm) + 32768) * 8192;
            span  = level - prev_level;
            bound = longint'(1) << ERR_BOUND_LOG2;
            shreg = '0;
            for (int b = 0; b < PDM_BITS; b++)
            begin
                desired = prev_level + (span * (b + 1)) / PDM_BITS;
                r = lfsr;
                r = r ^ (r << 13);
                r = r ^ (r >> 17);
                r = r ^ (r << 5);
                lfsr = r;
                noise = (longint'(r[15:0]) + longint'(r[31:16]) - 65535)
                        * longint'(dither_mult);
                down  = v_rc - (v_rc >> DECAY_SHIFT);
                up    = down + (longint'(1) << (FULL_SCALE_LOG2 - DECAY_SHIFT));
                thr   = thr_simple ? v_rc : (up + down) / 2;
                pulse = (desired + err_fb + noise) > thr;
                v_rc  = pulse ? up : down;
                err_fb = err_fb + desired - v_rc;
                if (err_fb > bound)
                    err_fb = bound;
                if (err_fb < -bound)
                    err_fb = -bound;
                shreg = {shreg[WORD_W-2:0], pulse};
                if (b % WORD_W == WORD_W - 1)
                begin
                    w.pattern    = shreg;
                    w.word_index = WIDX_W'(b / WORD_W);
                    w.last_word  = (b / WORD_W) == WORDS - 1;
                    words_due.push_back(w);
                    shreg = '0;
                end
            end
            prev_level = level;
        endfunction

        function void check_word(logic [WORD_W-1:0] pattern, logic [WIDX_W-1:0] word_index,
                                 logic last_word);
            pdm_word_t e;
            if (words_due.size() == 0)
            begin
                $display("%0t: unexpected PDM word %08h index %0d last %0b",
                         $time, pattern, word_index, last_word);
                errors++;
                return;
            end
            e = words_due.pop_front();
            if (pattern !== e.pattern)
            begin
                $display("%0t: pdm_word expected %08h got %08h", $time, e.pattern, pattern);
                errors++;
            end
            if (word_index !== e.word_index)
            begin
                $display("%0t: word_index expected %0d got %0d",
                         $time, e.word_index, word_index);
                errors++;
            end
            if (last_word !== e.last_word)
            begin
                $display("%0t: last_word expected %0b got %0b", $time, e.last_word, last_word);
                errors++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rcpdm_in_if  pcm_ch ();
    rcpdm_out_if pdm_ch ();

    // Flags from the stimulus to the word sink
    bit hold_sink_req = 1'b0;
    bit sink_steady   = 1'b0;

    int unsigned cycle_count = 0;

    pdm_bit_predictor pdm_pred = new();

    rc_feedback_pdm_modulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pcm       (pcm_ch),
        .pdm       (pdm_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: count cycles and give up well past the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("rc_feedback_pdm_modulator test failed");
            $finish;
        end
    end

    // Monitor: check words taken this edge first, then note the sample and
    // any register write, so the expectation order never depends on
    // process scheduling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pdm_ch.valid && pdm_ch.ready)
                pdm_pred.check_word(pdm_ch.pdm_word, pdm_ch.word_index, pdm_ch.last_word);
            if (pcm_ch.valid && pcm_ch.ready)
                pdm_pred.note_sample(pcm_ch.sample);
            if (cfg_wen)
                pdm_pred.write_reg(cfg_index, cfg_wdata);
        end
    end

    // Gap length: mostly short, now and then long
    function automatic int idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 3);
        else if (sel < 95)
            return $urandom_range(4, 16);
        else
            return $urandom_range(30, 120);
    endfunction

    // Word sink: random back-pressure, a long hold on request, none when
    // asked to run steady. One ready assignment per edge.
    initial
    begin : word_sink
        int stall_left;
        stall_left = 0;
        pdm_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_sink_req)
            begin
                hold_sink_req = 1'b0;
                stall_left    = SINK_HOLD_CYCLES;
            end
            else if (stall_left == 0 && !sink_steady && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_len();
            end
            if (stall_left > 0)
            begin
                pdm_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pdm_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one sample and hold it until taken; then either idle for a
    // while or leave valid up for the next sample.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input bit eager);
        int gap;
        pcm_ch.valid  <= 1'b1;
        pcm_ch.sample <= value;
        @(posedge clk);
        while (!pcm_ch.ready)
            @(posedge clk);
        gap = (eager || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            pcm_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted word has been taken, then
    // let the block settle so it is idle for register writes.
    task automatic wait_drained();
        pcm_ch.valid <= 1'b0;
        @(posedge clk);
        while (pdm_pred.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller drops the enable after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Gain data: the extremes often, junk above the field always
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        logic [CFG_DATA_W-1:0] data;
        data = $urandom();
        case ($urandom_range(0, 3))
            0:       data[GAIN_W-1:0] = '0;
            1:       data[GAIN_W-1:0] = '1;
            default: ;
        endcase
        return data;
    endfunction

    // Seed data: never zero here; zero is covered in the directed part
    function automatic logic [CFG_DATA_W-1:0] pick_seed();
        logic [CFG_DATA_W-1:0] data;
        case ($urandom_range(0, 5))
            0:       data = CFG_DATA_W'(1);
            1:       data = '1;
            default:
            begin
                data = $urandom();
                while (data == '0)
                    data = $urandom();
            end
        endcase
        return data;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] next_sample(
            input seq_kind_e kind, input logic signed [SAMPLE_W-1:0] prev_s);
        int v;
        case (kind)
            SEQ_WALK:
            begin
                v = int'(prev_s) + int'($urandom_range(0, 4095)) - 2048;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                return SAMPLE_W'(v);
            end
            SEQ_HOLD:
                return ($urandom_range(0, 5) == 0) ? SAMPLE_W'($urandom()) : prev_s;
            SEQ_SWING:
            begin
                if ($urandom_range(0, 1))
                    v = 32767 - int'($urandom_range(0, 255));
                else
                    v = -32768 + int'($urandom_range(0, 255));
                return SAMPLE_W'(v);
            end
            default:
                return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] level;
        seq_kind_e                  kind;
        int                         span;
        int                         fed;
        int                         phase;
        rst_n         <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_index     <= REG_SIMPLE_THR;
        cfg_wdata     <= '0;
        pcm_ch.valid  <= 1'b0;
        pcm_ch.sample <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: full-scale swings both ways, the sign boundary,
        // alternating bit patterns and a repeated level with no slope
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        wait_drained();

        // Voltage as threshold, dither off, all-ones seed; junk above each
        // field must be ignored
        write_reg(REG_SIMPLE_THR, 32'hFFFF_FFFF);
        write_reg(REG_DITHER_GAIN, 32'hFFFF_FF80);
        write_reg(REG_PRNG_SEED, 32'hFFFF_FFFF);
        cfg_wen <= 1'b0;
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd12345, 1'b1);
        send_sample(16'sd3, 1'b0);
        wait_drained();

        // Zero seed at full gain: the generator sticks, dither is a constant
        // negative offset
        write_reg(REG_SIMPLE_THR, 32'h0000_0002);
        write_reg(REG_DITHER_GAIN, 32'h0000_007F);
        write_reg(REG_PRNG_SEED, 32'h0000_0000);
        cfg_wen <= 1'b0;
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        wait_drained();

        // Smallest seed and gain; a write to the spare index changes nothing
        write_reg(REG_DITHER_GAIN, 32'h0000_0001);
        write_reg(REG_PRNG_SEED, 32'h0000_0001);
        write_reg(REG_SPARE, $urandom());
        cfg_wen <= 1'b0;
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        send_sample(16'sd32766, 1'b0);
        wait_drained();

        // Random phases: new register settings between phases, a shaped
        // sample sequence within each. Phase 1 holds the sink off for a long
        // stretch, phase 2 runs with no idling at all, phase 3 pauses the
        // sender halfway until the pipe is empty.
        fed   = 0;
        phase = 0;
        level = '0;
        while (fed < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1))
                write_reg(REG_SIMPLE_THR, $urandom());
            if ($urandom_range(0, 1))
                write_reg(REG_DITHER_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_PRNG_SEED, pick_seed());
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, $urandom());
            cfg_wen <= 1'b0;

            kind        = seq_kind_e'($urandom_range(0, 3));
            span        = $urandom_range(8, 24);
            sink_steady = (phase == 2);
            if (phase == 1)
                hold_sink_req = 1'b1;
            for (int i = 0; i < span && fed < RANDOM_ITEMS; i++)
            begin
                level = next_sample(kind, level);
                send_sample(level, phase == 2);
                fed++;
                if (phase == 3 && i == span / 2)
                    wait_drained();
            end
            wait_drained();
            sink_steady = 1'b0;
            phase++;
        end

        if (pdm_pred.errors == 0)
        begin
            $display("rc_feedback_pdm_modulator test passed");
        end
        else
        begin
            $display("rc_feedback_pdm_modulator test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/rcpdm_pkg.sv
hdl/rcpdm_in_if.sv
hdl/rcpdm_out_if.sv
hdl/rcpdm_dither.sv
hdl/rc_feedback_pdm_modulator.sv
test/tb.sv
